FILE: sv/rle_then_repeating_key_xor_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef RLE_THEN_REPEATING_KEY_XOR_TOP_DEFINES_SVH
`define RLE_THEN_REPEATING_KEY_XOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RLEXOR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define RLEXOR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rlexor_pkg.sv
package rlexor_pkg;

    localparam int CHAR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int KEY_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CHAR_W-1:0] COPIES_MAX = 7'd127;
    localparam logic [BYTE_W-1:0] COUNT_MARK = 8'h80;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH = 2'd0,
        CFG_KEY_LOW    = 2'd1,
        CFG_KEY_HIGH   = 2'd2
    } cfg_reg_t;

    // One flush request from the front to the back
    typedef struct packed {
        logic              err;       // non-ASCII input, emit the error result
        logic              fin;       // end of message, clear key position after
        logic              cnt_v;     // count byte present
        logic [BYTE_W-1:0] cnt_byte;
        logic              chr_v;     // character byte present
        logic [CHAR_W-1:0] chr;
    } rlexor_cmd_t;

    // Back-end phase within one request
    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } bk_phase_t;

endpackage

FILE: sv/rlexor_front.sv
module rlexor_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_char,
    input  logic                     end_of_input,
    output logic                     push,
    output rlexor_pkg::rlexor_cmd_t  push_cmd,
    input  logic                     full
);
    import rlexor_pkg::*;

    logic [CHAR_W-1:0] run_char_reg, run_char_next;
    logic [CHAR_W-1:0] run_count_reg, run_count_next;
    logic              halted_reg, halted_next;
    logic              accept;
    rlexor_cmd_t       flush_cmd;

    // Take items freely once halted; otherwise need room in the queue
    assign in_ready = halted_reg || !full;
    assign accept   = in_valid && in_ready;

    // Build the flush request for the pending run
    always_comb
    begin
        flush_cmd          = '0;
        flush_cmd.cnt_v    = (run_count_reg != '0);
        flush_cmd.cnt_byte = (BYTE_W'(run_count_reg) + BYTE_W'(1)) | COUNT_MARK;
        flush_cmd.chr_v    = (run_char_reg != '0);
        flush_cmd.chr      = run_char_reg;
    end

    // Classify the accepted item
    always_comb
    begin
        run_char_next  = run_char_reg;
        run_count_next = run_count_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        push_cmd       = flush_cmd;
        if (accept && !halted_reg)
        begin
            priority if (end_of_input)
            begin
                push           = 1'b1;
                push_cmd.fin   = 1'b1;
                run_char_next  = '0;
                run_count_next = '0;
            end
            else if (in_char[7])
            begin
                push        = 1'b1;
                push_cmd    = '0;
                push_cmd.err = 1'b1;
                halted_next = 1'b1;
            end
            else if (in_char[CHAR_W-1:0] == run_char_reg && run_count_reg < COPIES_MAX)
            begin
                run_count_next = run_count_reg + CHAR_W'(1);
            end
            else
            begin
                push           = flush_cmd.cnt_v || flush_cmd.chr_v;
                run_char_next  = in_char[CHAR_W-1:0];
                run_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_char_reg  <= '0;
            run_count_reg <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            run_char_reg  <= run_char_next;
            run_count_reg <= run_count_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

FILE: sv/rlexor_fifo.sv
module rlexor_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rlexor_pkg::rlexor_cmd_t  push_cmd,
    output logic                     full,
    input  logic                     pop,
    output rlexor_pkg::rlexor_cmd_t  head,
    output logic                     empty
);
    import rlexor_pkg::*;

    rlexor_cmd_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/rlexor_back.sv
module rlexor_back #(
    parameter int KPOS_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlexor_pkg::rlexor_cmd_t       head,
    input  logic                          empty,
    output logic                          pop,
    input  logic [rlexor_pkg::LEN_W-1:0]  len_use,
    input  logic [2*rlexor_pkg::KEY_W-1:0] key_all,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_value,
    output logic                          last_of_item,
    output logic                          message_end,
    output logic                          not_ascii
);
    import rlexor_pkg::*;

    bk_phase_t         phase_reg, phase_next;
    logic [KPOS_W-1:0] kpos_reg, kpos_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic              last_reg, last_next;
    logic              mend_reg, mend_next;
    logic              err_reg, err_next;

    logic              step;
    logic              emit;
    logic              finish;
    logic [KPOS_W:0]   kpos_inc;
    logic [KPOS_W-1:0] kpos_adv;
    logic [BYTE_W-1:0] key_byte;
    logic              send_count;

    // Output slot is free or drains this cycle
    assign step = !out_valid_reg || out_ready;

    // Rolling key position and its byte
    assign kpos_inc = {1'b0, kpos_reg} + (KPOS_W+1)'(1);
    assign kpos_adv = ((LEN_W+1)'(kpos_inc) >= (LEN_W+1)'(len_use)) ? '0
                                                                     : kpos_inc[KPOS_W-1:0];
    assign key_byte = key_all[{4'(kpos_reg), 3'b000} +: BYTE_W];

    assign send_count = head.cnt_v && (phase_reg == PH_FIRST);

    // Phase sequencing: a request with both bytes takes two steps
    always_comb
    begin
        phase_next = phase_reg;
        if (step && !empty && !head.err)
        begin
            unique case (phase_reg)
                PH_FIRST:  phase_next = (head.cnt_v && head.chr_v) ? PH_SECOND : PH_FIRST;
                PH_SECOND: phase_next = PH_FIRST;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    // Emit at most one byte per step, pop when the request is done
    always_comb
    begin
        emit       = 1'b0;
        finish     = 1'b0;
        value_next = value_reg;
        last_next  = last_reg;
        mend_next  = mend_reg;
        err_next   = err_reg;
        kpos_next  = kpos_reg;
        if (step && !empty)
        begin
            priority if (head.err)
            begin
                emit       = 1'b1;
                finish     = 1'b1;
                value_next = '0;
                last_next  = 1'b1;
                mend_next  = 1'b0;
                err_next   = 1'b1;
            end
            else if (send_count)
            begin
                emit       = 1'b1;
                finish     = !head.chr_v;
                value_next = head.cnt_byte ^ key_byte;
                last_next  = !head.chr_v;
                mend_next  = head.fin;
                err_next   = 1'b0;
                kpos_next  = kpos_adv;
            end
            else if (head.chr_v)
            begin
                emit       = 1'b1;
                finish     = 1'b1;
                value_next = {1'b0, head.chr} ^ key_byte;
                last_next  = 1'b1;
                mend_next  = head.fin;
                err_next   = 1'b0;
                kpos_next  = kpos_adv;
            end
            else
            begin
                finish = 1'b1;
            end
            // End of message restarts the key
            if (finish && head.fin && !head.err)
            begin
                kpos_next = '0;
            end
        end
    end

    assign pop            = finish;
    assign out_valid_next = step ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            kpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kpos_reg      <= kpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        mend_reg  <= mend_next;
        err_reg   <= err_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = value_reg;
    assign last_of_item = last_reg;
    assign message_end  = mend_reg;
    assign not_ascii    = err_reg;

endmodule

FILE: sv/rle_then_repeating_key_xor_top.sv
// Channel   Direction  Handshake            Payload
// in        in         in_valid/in_ready    in_char, end_of_input
// out       out        out_valid/out_ready  out_value, last_of_item, message_end, not_ascii
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each input item yields 0 to 2 result bytes; the back end sends them through the
// output register at one byte per cycle while out_ready is high.
// A flush request is written to a queue slot at the accepting edge, and the back end
// loads the output register from the queue head when the output slot is free.
// Reset clears the run, key position, halt flag and queue; no clearing pass.
// Output stalls back up through the two-entry request queue to in_ready.
// cfg_ready is always high.
module rle_then_repeating_key_xor_top #(
    parameter int KEY_MAX = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_char,
    input  logic                              end_of_input,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_value,
    output logic                              last_of_item,
    output logic                              message_end,
    output logic                              not_ascii,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlexor_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlexor_pkg::CFG_W-1:0]      cfg_data
);
    import rlexor_pkg::*;

    localparam int KPOS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [LEN_W-1:0]   key_len_reg;
    logic [KEY_W-1:0]   key_low_reg;
    logic [KEY_W-1:0]   key_high_reg;
    logic [LEN_W-1:0]   len_use;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    rlexor_cmd_t        push_cmd;
    rlexor_cmd_t        head;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg  <= LEN_W'(1);
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_KEY_LENGTH: key_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_KEY_LOW:    key_low_reg  <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp key length to 1..KEY_MAX
    always_comb
    begin
        priority if (key_len_reg == '0)
            len_use = LEN_W'(1);
        else if (key_len_reg > LEN_W'(KEY_MAX))
            len_use = LEN_W'(KEY_MAX);
        else
            len_use = key_len_reg;
    end

    rlexor_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .end_of_input (end_of_input),
        .push         (push),
        .push_cmd     (push_cmd),
        .full         (full)
    );

    rlexor_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    rlexor_back #(
        .KPOS_W (KPOS_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .len_use      (len_use),
        .key_all      ({key_high_reg, key_low_reg}),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .last_of_item (last_of_item),
        .message_end  (message_end),
        .not_ascii    (not_ascii)
    );

endmodule

FILE: sv/rlexor_checker.sv
`include "rle_then_repeating_key_xor_top_defines.svh"

module rlexor_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_char,
    input logic       end_of_input,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_value,
    input logic       last_of_item,
    input logic       message_end,
    input logic       not_ascii
);

    // Waiting request holds its payload
    `RLEXOR_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_char) && $stable(end_of_input), "waiting request changed")

    // Stalled result holds its payload
    `RLEXOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(last_of_item), "stalled result changed")

    // Error result is a lone zero byte outside any message end
    `RLEXOR_ASSERT_NOW(a_err_shape, out_valid && not_ascii, out_value == 8'd0 && last_of_item && !message_end, "malformed error result")

    // An accepted error result is not directly followed by another valid result
    `RLEXOR_ASSERT_NEXT(a_err_silent, out_valid && out_ready && not_ascii, !out_valid, "result after error")

endmodule

bind rle_then_repeating_key_xor_top rlexor_checker u_rlexor_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .last_of_item (last_of_item),
    .message_end  (message_end),
    .not_ascii    (not_ascii)
);

FILE: tb/rlexor_stream_check.sv
module rlexor_stream_check #(
    parameter int KEY_MAX = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       in_char,
    input  logic                             end_of_input,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       out_value,
    input  logic                             last_of_item,
    input  logic                             message_end,
    input  logic                             not_ascii,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rlexor_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rlexor_pkg::CFG_W-1:0]     cfg_data,
    output int                               fail_count,
    output int                               bytes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import rlexor_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last_of_item;
        logic       message_end;
        logic       not_ascii;
    } cipher_byte_t;

    // Key registers as the block holds them
    logic [LEN_W-1:0] key_len;
    logic [KEY_W-1:0] key_lo;
    logic [KEY_W-1:0] key_hi;

    // Encoder state
    logic [6:0] run_char;
    logic [6:0] run_count;
    logic [3:0] key_pos;
    logic       halted;

    cipher_byte_t cipher_bytes_pending[$];
    int           mismatches;
    int           reported;

    function automatic int unsigned key_span();
        if (key_len == 0)
        begin
            return 1;
        end
        if (key_len > KEY_MAX)
        begin
            return KEY_MAX;
        end
        return key_len;
    endfunction

    function automatic logic [7:0] key_at(input logic [3:0] pos);
        int idx;
        idx = pos;
        if (idx < 8)
        begin
            return key_lo[idx*8 +: 8];
        end
        return key_hi[(idx-8)*8 +: 8];
    endfunction

    // Encrypt one byte with the current key byte, then advance the position
    function automatic void emit_byte(input logic [7:0] plain, input logic fin);
        cipher_byte_t b;
        int unsigned  step;
        b.value        = plain ^ key_at(key_pos);
        b.last_of_item = 1'b0;
        b.message_end  = fin;
        b.not_ascii    = 1'b0;
        cipher_bytes_pending.push_back(b);
        step    = key_pos + 1;
        key_pos = (step >= key_span()) ? 4'd0 : step[3:0];
    endfunction

    // Flush the pending run: count byte if it repeated, then the character if nonzero
    function automatic void flush_run(input logic fin);
        if (run_count != 0)
        begin
            emit_byte(({1'b0, run_count} + 8'd1) | COUNT_MARK, fin);
        end
        if (run_char != 0)
        begin
            emit_byte({1'b0, run_char}, fin);
        end
    endfunction

    // Work out the cipher bytes that one input request causes
    function automatic void encode_item(input logic [7:0] ch, input logic eoi);
        cipher_byte_t tail;
        int           depth;
        if (halted)
        begin
            return;
        end
        depth = cipher_bytes_pending.size();
        if (eoi)
        begin
            flush_run(1'b1);
            run_char  = '0;
            run_count = '0;
            key_pos   = '0;
        end
        else if (ch[7])
        begin
            tail.value        = 8'h00;
            tail.last_of_item = 1'b1;
            tail.message_end  = 1'b0;
            tail.not_ascii    = 1'b1;
            cipher_bytes_pending.push_back(tail);
            halted = 1'b1;
            return;
        end
        else if (ch[6:0] == run_char && run_count < COPIES_MAX)
        begin
            run_count = run_count + 7'd1;
        end
        else
        begin
            flush_run(1'b0);
            run_char  = ch[6:0];
            run_count = '0;
        end
        // Mark the final byte of this request
        if (cipher_bytes_pending.size() > depth)
        begin
            tail = cipher_bytes_pending.pop_back();
            tail.last_of_item = 1'b1;
            cipher_bytes_pending.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cipher_byte_t got;
        cipher_byte_t want;
        if (!rst_n)
        begin
            key_len    = 5'd1;
            key_lo     = '0;
            key_hi     = '0;
            run_char   = '0;
            run_count  = '0;
            key_pos    = '0;
            halted     = 1'b0;
            cipher_bytes_pending.delete();
            mismatches = 0;
            reported   = 0;
            fail_count <= 0;
            bytes_due  <= 0;
        end
        else
        begin
            // Compare each accepted result with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{out_value, last_of_item, message_end, not_ascii};
                if (cipher_bytes_pending.size() == 0)
                begin
                    mismatches++;
                    if (reported < 10)
                    begin
                        $display("%0t: result with nothing pending: value %02h last %0b end %0b err %0b",
                                 $realtime, got.value, got.last_of_item, got.message_end,
                                 got.not_ascii);
                    end
                    reported++;
                end
                else
                begin
                    want = cipher_bytes_pending.pop_front();
                    if (got.value != want.value || got.last_of_item != want.last_of_item ||
                        got.message_end != want.message_end || got.not_ascii != want.not_ascii)
                    begin
                        mismatches++;
                        if (reported < 10)
                        begin
                            $display("%0t: mismatch: expected value %02h last %0b end %0b err %0b, got value %02h last %0b end %0b err %0b",
                                     $realtime, want.value, want.last_of_item, want.message_end,
                                     want.not_ascii, got.value, got.last_of_item,
                                     got.message_end, got.not_ascii);
                        end
                        reported++;
                    end
                end
            end

            // Apply register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_LENGTH: key_len = cfg_data[LEN_W-1:0];
                    CFG_KEY_LOW:    key_lo  = cfg_data;
                    CFG_KEY_HIGH:   key_hi  = cfg_data;
                    default:        ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                encode_item(in_char, end_of_input);
            end

            fail_count <= mismatches;
            bytes_due  <= cipher_bytes_pending.size();
        end
    end

endmodule

FILE: tb/tb_rle_then_repeating_key_xor_top.sv
module tb_rle_then_repeating_key_xor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlexor_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           in_char;
    logic                 end_of_input;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_value;
    logic                 last_of_item;
    logic                 message_end;
    logic                 not_ascii;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int bytes_due;

    // Sender pacing and pressure bookkeeping
    int items_sent;
    int burst_left;
    bit steady;
    int long_runs_left;
    bit want_long;
    int holds_asked;
    int holds_done;

    rle_then_repeating_key_xor_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .last_of_item (last_of_item),
        .message_end  (message_end),
        .not_ascii    (not_ascii),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rlexor_stream_check check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_char      (in_char),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .last_of_item (last_of_item),
        .message_end  (message_end),
        .not_ascii    (not_ascii),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .bytes_due    (bytes_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request and hold it until accepted; take a break at burst ends
    task automatic send_char(input logic [7:0] ch, input logic eoi);
        int gap;
        in_valid     <= 1'b1;
        in_char      <= ch;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (!steady)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 4);
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Stop sending until every predicted byte is out, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [CFG_W-1:0] key_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Load a new key while the block is idle
    task automatic load_key(input logic [LEN_W-1:0] len, input bit poke_spare);
        logic [CFG_W-1:0] word;
        drain();
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = len;
        write_reg(CFG_KEY_LENGTH, word);
        write_reg(CFG_KEY_LOW, key_word());
        write_reg(CFG_KEY_HIGH, key_word());
        if (poke_spare)
        begin
            write_reg(CFG_SPARE, {$urandom, $urandom});
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Send runs over a small alphabet, closing most messages with an end request
    task automatic send_message();
        logic [6:0] alphabet [3];
        logic [6:0] ch;
        int         runs;
        int         len;
        int         pick;
        alphabet[0] = 7'($urandom_range(1, 126));
        alphabet[1] = 7'($urandom_range(1, 126));
        alphabet[2] = 7'($urandom_range(1, 126));
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++)
        begin
            pick = $urandom_range(0, 9);
            ch   = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : alphabet[pick % 3];
            pick = $urandom_range(0, 99);
            if (want_long || (pick >= 97 && long_runs_left > 0))
            begin
                // Overflow the run counter at least once
                len = $urandom_range(129, 200);
                long_runs_left--;
                want_long = 1'b0;
            end
            else if (pick < 70)
            begin
                len = $urandom_range(1, 3);
            end
            else
            begin
                len = $urandom_range(4, 12);
            end
            repeat (len) send_char({1'b0, ch}, 1'b0);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Receiver: switch among stall patterns; honor long hold-off requests
    initial
    begin : receiver
        int mode;
        int left;
        int tick;
        out_ready = 1'b0;
        left = 0;
        tick = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 80);
                end
                left--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (tick % 4 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0] len_plan [6];
        logic [LEN_W-1:0] len;
        int               phase;
        int               quota;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_char      = '0;
        end_of_input = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        items_sent   = 0;
        burst_left   = 4;
        steady       = 1'b1;
        long_runs_left = 2;
        want_long    = 1'b0;
        holds_asked  = 0;
        holds_done   = 0;
        len_plan     = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key: length one, all bytes zero
        send_char("A", 1'b0);
        send_char("A", 1'b0);
        send_char("A", 1'b0);
        send_char("B", 1'b0);
        send_char(8'h00, 1'b1);

        load_key(5'd5, 1'b1);
        // Empty message, character ignored on end
        send_char(8'hFF, 1'b1);
        // Leading zeros extend the initial zero run
        send_char(8'h00, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("C", 1'b0);
        send_char(8'h80, 1'b1);
        // Top character, then a zero run that flushes to nothing
        send_char(8'h7F, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h55, 1'b1);
        // Shrink the key below the live position mid-message
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("c", 1'b0);
        send_char("d", 1'b0);
        load_key(5'd2, 1'b0);
        send_char("e", 1'b0);
        send_char(8'h2A, 1'b1);

        // Random messages, new key per phase
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            len = (phase < 6) ? len_plan[phase] : LEN_W'($urandom_range(0, 31));
            load_key(len, $urandom_range(0, 3) == 0);
            steady    = ($urandom_range(0, 3) == 0);
            want_long = (phase == 1);
            if (phase == 2)
            begin
                holds_asked++;
            end
            quota = items_sent + $urandom_range(40, 100);
            while (items_sent < quota)
            begin
                send_message();
            end
            phase++;
        end

        // Non-ASCII request halts the block; later requests are ignored
        drain();
        send_char(8'($urandom_range(128, 255)), 1'b0);
        repeat (4) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();

        if (bytes_due != 0)
        begin
            $display("%0d predicted results never arrived", bytes_due);
        end
        if (fail_count == 0 && bytes_due == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: rle_then_repeating_key_xor_top.f
+incdir+sv
sv/rlexor_pkg.sv
sv/rlexor_front.sv
sv/rlexor_fifo.sv
sv/rlexor_back.sv
sv/rle_then_repeating_key_xor_top.sv
sv/rlexor_checker.sv
tb/rlexor_stream_check.sv
tb/tb_rle_then_repeating_key_xor_top.sv
